>>> hdl/qnorm_pkg.sv
package qnorm_pkg;

  localparam int CW = 16;
  localparam int FB = CW - 2;

  typedef struct packed {
    logic signed [CW-1:0] q_w;
    logic signed [CW-1:0] q_x;
    logic signed [CW-1:0] q_y;
    logic signed [CW-1:0] q_z;
  } qnorm_in_t;

  typedef struct packed {
    logic signed [CW-1:0] out_w;
    logic signed [CW-1:0] out_x;
    logic signed [CW-1:0] out_y;
    logic signed [CW-1:0] out_z;
    logic                 passed_through;
  } qnorm_out_t;

endpackage

>>> hdl/qnorm_stage.sv
// One registered step of a pipelined unit: data and its valid bit move together.
module qnorm_stage
  import qnorm_pkg::*;
#(
  parameter int W = 8
) (
  input  logic         clk,
  input  logic         rst_n,
  input  logic         v_in,
  input  logic [W-1:0] d_in,
  output logic         v_out,
  output logic [W-1:0] d_out
);
  logic         v_r;
  logic [W-1:0] d_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      v_r <= 1'b0;
    end else begin
      v_r <= v_in;
    end
    d_r <= d_in;
  end

  assign v_out = v_r;
  assign d_out = d_r;
endmodule

>>> hdl/quaternion_normalize.sv
// Channel   Direction  Handshake            Payload
// request   in         start & !busy        in_data  (qnorm_in_t)
// result    out        out_valid, 1 cycle   out_data (qnorm_out_t)
// config    in         cfg_we               cfg_data (min_norm, 16 bits)
//
// A request may be started in every cycle; busy is always low.
// The pipeline has 1 squaring stage, 1 sum stage,
// 17 square-root stages (one result bit each), 1 compare stage and
// 16 stages of the four parallel restoring dividers (one quotient bit each),
// plus the output register.
// Synchronous reset clears all valid bits and sets min_norm to 0.
// The receiver cannot stall, so the pipeline never holds.
module quaternion_normalize
  import qnorm_pkg::*;
(
  input  logic       clk,
  input  logic       rst_n,
  input  logic       start,
  output logic       busy,
  input  qnorm_in_t  in_data,
  output logic       out_valid,
  output qnorm_out_t out_data,
  input  logic       cfg_we,
  input  logic [15:0] cfg_data
);
  localparam int SW = 2 * CW + 2;     // sum of four squares
  localparam int RW = CW + 1;         // root bits
  localparam int NW = CW + FB + 1;    // dividend width
  localparam int QW = FB + 2;         // quotient bits

  logic [15:0] min_norm_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      min_norm_r <= '0;
    end else if (cfg_we) begin
      min_norm_r <= cfg_data;
    end
  end

  assign busy = 1'b0;

  // Stage 1: magnitudes, signs and squares.
  logic            v1_r;
  qnorm_in_t       in1_r;
  logic [3:0]      neg1_r;
  logic [CW-1:0]   mag1_r [4];
  logic [2*CW-1:0] sq1_r  [4];
  logic [CW-1:0]   comp   [4];

  assign comp[0] = in_data.q_w;
  assign comp[1] = in_data.q_x;
  assign comp[2] = in_data.q_y;
  assign comp[3] = in_data.q_z;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      v1_r <= 1'b0;
    end else begin
      v1_r <= start;
    end
    in1_r <= in_data;
    for (int i = 0; i < 4; i++) begin
      logic [CW-1:0] m;
      m = comp[i][CW-1] ? (~comp[i] + 1'b1) : comp[i];
      neg1_r[i] <= comp[i][CW-1];
      mag1_r[i] <= m;
      sq1_r[i]  <= m * m;
    end
  end

  // Stage 2: sum of squares.
  logic          v2_r;
  qnorm_in_t     in2_r;
  logic [3:0]    neg2_r;
  logic [CW-1:0] mag2_r [4];
  logic [SW-1:0] sum2_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      v2_r <= 1'b0;
    end else begin
      v2_r <= v1_r;
    end
    in2_r  <= in1_r;
    neg2_r <= neg1_r;
    mag2_r <= mag1_r;
    sum2_r <= SW'(sq1_r[0]) + SW'(sq1_r[1]) + SW'(sq1_r[2]) + SW'(sq1_r[3]);
  end

  // Square root, one root bit per stage, restoring digit recurrence.
  logic          sv_r  [RW+1];
  qnorm_in_t     sin_r [RW+1];
  logic [3:0]    sneg_r[RW+1];
  logic [CW-1:0] smag_r[RW+1][4];
  logic [SW-1:0] srem_r[RW+1];
  logic [RW-1:0] sroot_r[RW+1];
  logic [SW-1:0] sval_r[RW+1];

  assign sv_r[0]    = v2_r;
  assign sin_r[0]   = in2_r;
  assign sneg_r[0]  = neg2_r;
  assign smag_r[0]  = mag2_r;
  assign srem_r[0]  = '0;
  assign sroot_r[0] = '0;
  assign sval_r[0]  = sum2_r;

  for (genvar k = 0; k < RW; k++) begin : g_sqrt
    logic [SW-1:0] rem_sh, trial;
    logic [RW-1:0] root_n;
    logic [SW-1:0] rem_n;
    always_comb begin
      rem_sh = {srem_r[k][SW-3:0], sval_r[k][SW-1 -: 2]};
      trial  = SW'({sroot_r[k], 2'b01});
      if (rem_sh >= trial) begin
        rem_n  = rem_sh - trial;
        root_n = {sroot_r[k][RW-2:0], 1'b1};
      end else begin
        rem_n  = rem_sh;
        root_n = {sroot_r[k][RW-2:0], 1'b0};
      end
    end
    always_ff @(posedge clk) begin
      if (!rst_n) begin
        sv_r[k+1] <= 1'b0;
      end else begin
        sv_r[k+1] <= sv_r[k];
      end
      sin_r[k+1]   <= sin_r[k];
      sneg_r[k+1]  <= sneg_r[k];
      smag_r[k+1]  <= smag_r[k];
      srem_r[k+1]  <= rem_n;
      sroot_r[k+1] <= root_n;
      sval_r[k+1]  <= {sval_r[k][SW-3:0], 2'b00};
    end
  end

  // Compare stage: decide pass-through and form the rounded dividends.
  logic          v3_r;
  qnorm_in_t     in3_r;
  logic [3:0]    neg3_r;
  logic          pass3_r;
  logic [RW-1:0] norm3_r;
  logic [NW-1:0] num3_r [4];

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      v3_r <= 1'b0;
    end else begin
      v3_r <= sv_r[RW];
    end
    in3_r   <= sin_r[RW];
    neg3_r  <= sneg_r[RW];
    norm3_r <= sroot_r[RW];
    pass3_r <= (sroot_r[RW] <= RW'(min_norm_r));
    for (int i = 0; i < 4; i++) begin
      num3_r[i] <= (NW'(smag_r[RW][i]) << FB) + NW'(sroot_r[RW] >> 1);
    end
  end

  // Four restoring dividers in lockstep, one quotient bit per stage.
  logic          dv_r   [QW+1];
  qnorm_in_t     din_r  [QW+1];
  logic [3:0]    dneg_r [QW+1];
  logic          dpass_r[QW+1];
  logic [RW-1:0] dden_r [QW+1];
  logic [NW-1:0] dnum_r [QW+1][4];
  logic [RW:0]   drem_r [QW+1][4];
  logic [QW-1:0] dq_r   [QW+1][4];

  assign dv_r[0]    = v3_r;
  assign din_r[0]   = in3_r;
  assign dneg_r[0]  = neg3_r;
  assign dpass_r[0] = pass3_r;
  assign dden_r[0]  = norm3_r;

  for (genvar i = 0; i < 4; i++) begin : g_div_init
    // Top bits above the quotient window are below the divisor whenever the norm is nonzero.
    assign drem_r[0][i] = (RW+1)'(num3_r[i] >> QW);
    assign dnum_r[0][i] = num3_r[i] << (NW - QW);
    assign dq_r[0][i]   = '0;
  end

  for (genvar k = 0; k < QW; k++) begin : g_div
    logic [RW:0]   rem_n [4];
    logic [QW-1:0] q_n   [4];
    always_comb begin
      for (int i = 0; i < 4; i++) begin
        logic [RW+1:0] sh;
        sh = {drem_r[k][i], dnum_r[k][i][NW-1]};
        if (sh >= (RW+2)'(dden_r[k])) begin
          rem_n[i] = (RW+1)'(sh - (RW+2)'(dden_r[k]));
          q_n[i]   = {dq_r[k][i][QW-2:0], 1'b1};
        end else begin
          rem_n[i] = (RW+1)'(sh);
          q_n[i]   = {dq_r[k][i][QW-2:0], 1'b0};
        end
      end
    end
    always_ff @(posedge clk) begin
      if (!rst_n) begin
        dv_r[k+1] <= 1'b0;
      end else begin
        dv_r[k+1] <= dv_r[k];
      end
      din_r[k+1]   <= din_r[k];
      dneg_r[k+1]  <= dneg_r[k];
      dpass_r[k+1] <= dpass_r[k];
      dden_r[k+1]  <= dden_r[k];
      for (int i = 0; i < 4; i++) begin
        dnum_r[k+1][i] <= dnum_r[k][i] << 1;
        drem_r[k+1][i] <= rem_n[i];
        dq_r[k+1][i]   <= q_n[i];
      end
    end
  end

  // Output register: apply signs or pass the request through.
  qnorm_out_t    od_nxt;
  logic [CW-1:0] res [4];

  always_comb begin
    for (int i = 0; i < 4; i++) begin
      logic [CW-1:0] q;
      q = CW'(dq_r[QW][i]);
      res[i] = dneg_r[QW][i] ? (~q + 1'b1) : q;
    end
  end

  always_comb begin
    if (dpass_r[QW]) begin
      od_nxt = {din_r[QW].q_w, din_r[QW].q_x, din_r[QW].q_y, din_r[QW].q_z, 1'b1};
    end else begin
      od_nxt = {res[0], res[1], res[2], res[3], 1'b0};
    end
  end

  qnorm_stage #(
    .W($bits(qnorm_out_t))
  ) u_out (
    .clk(clk),
    .rst_n(rst_n),
    .v_in(dv_r[QW]),
    .d_in(od_nxt),
    .v_out(out_valid),
    .d_out(out_data)
  );

  // A rising output strobe is always preceded by a valid request in the last divider stage.
  a_latency: assert property (@(posedge clk) disable iff (!rst_n)
    $rose(out_valid) |-> $past(dv_r[QW]))
    else $error("output strobe without request in last divider stage");
  // The w component of a normalized result never exceeds unity magnitude.
  a_unit: assert property (@(posedge clk) disable iff (!rst_n)
    (out_valid && !out_data.passed_through) |->
      ($signed(out_data.out_w) <= $signed(CW'(1 << FB))) &&
      ($signed(out_data.out_w) >= -$signed(CW'(1 << FB))))
    else $error("normalized component out of range");
  // Zero norm always passes through.
  a_zero: assert property (@(posedge clk) disable iff (!rst_n)
    (v3_r && norm3_r == '0) |-> pass3_r)
    else $error("zero norm not passed through");
endmodule

>>> test/quaternion_normalize_tb.sv
module quaternion_normalize_tb
  import qnorm_pkg::*;
();

  // The drain runs past the full pipeline depth.
  localparam int PIPE_DEPTH = 37;
  localparam int DRAIN_CYCLES = PIPE_DEPTH + 20;
  localparam int CYCLE_LIMIT = 200000;
  localparam int RANDOM_REQUESTS = 500;
  localparam int ONE_Q = 1 << FB;

  logic       clk;
  logic       rst_n;
  logic       start;
  logic       busy;
  qnorm_in_t  in_data;
  logic       out_valid;
  qnorm_out_t out_data;
  logic       cfg_we;
  logic [15:0] cfg_data;

  quaternion_normalize dut (
    .clk(clk),
    .rst_n(rst_n),
    .start(start),
    .busy(busy),
    .in_data(in_data),
    .out_valid(out_valid),
    .out_data(out_data),
    .cfg_we(cfg_we),
    .cfg_data(cfg_data)
  );

  // Our own copy of the threshold register, updated with every write we make.
  logic [15:0] min_norm_shadow;

  // Expected unit quaternions, oldest first.
  qnorm_out_t unit_q_fifo[$];
  int errors = 0;
  int cycle_count = 0;

  // Directed requests. Rows with has_golden set carry a hand-computed answer,
  // the others are checked against the predictor only.
  typedef struct {
    logic [15:0] thresh;
    qnorm_in_t   q;
    bit          has_golden;
    qnorm_out_t  golden;
  } directed_row_t;

  directed_row_t directed_rows[$];

  initial begin
    clk = 1'b0;
    forever #5 clk = ~clk;
  end

  // Free-running cycle counter with a hard stop so a hung pipeline cannot
  // keep the simulation alive.
  always @(posedge clk) begin
    cycle_count <= cycle_count + 1;
    if (cycle_count > CYCLE_LIMIT) begin
      $display("Some tests failed");
      $finish;
    end
  end

  // Integer square root, one result bit per pass, on a 65-bit sum so the
  // carry-out case never shows up at this width but stays representable.
  function automatic logic [32:0] int_sqrt(input logic [64:0] s);
    logic [32:0] root;
    logic [65:0] trial;
    root = '0;
    for (int b = 32; b >= 0; b--) begin
      trial = {1'b0, root | (33'd1 << b)} * (root | (33'd1 << b));
      if (trial <= {1'b0, s})
        root = root | (33'd1 << b);
    end
    return root;
  endfunction

  // Predicts the result for one quaternion under the current threshold: floor norm,
  // pass-through at or below it, else round-half-away division of each magnitude by the norm.
  function automatic qnorm_out_t predict_unit_q(input qnorm_in_t q,
                                                input logic [15:0] thresh);
    qnorm_out_t r;
    logic signed [CW-1:0] comp [4];
    logic [CW-1:0] mag [4];
    logic [64:0] sum_sq;
    logic [32:0] norm;
    logic [63:0] quo;
    comp[0] = q.q_w;
    comp[1] = q.q_x;
    comp[2] = q.q_y;
    comp[3] = q.q_z;
    sum_sq = '0;
    for (int i = 0; i < 4; i++) begin
      mag[i] = comp[i][CW-1] ? CW'(-comp[i]) : comp[i];
      sum_sq = sum_sq + 65'(mag[i]) * 65'(mag[i]);
    end
    norm = int_sqrt(sum_sq);
    if (norm <= 33'(thresh)) begin
      r.out_w = q.q_w;
      r.out_x = q.q_x;
      r.out_y = q.q_y;
      r.out_z = q.q_z;
      r.passed_through = 1'b1;
    end else begin
      for (int i = 0; i < 4; i++) begin
        quo = ((64'(mag[i]) << FB) + 64'(norm >> 1)) / 64'(norm);
        comp[i] = comp[i][CW-1] ? CW'(-quo) : CW'(quo);
      end
      r.out_w = comp[0];
      r.out_x = comp[1];
      r.out_y = comp[2];
      r.out_z = comp[3];
      r.passed_through = 1'b0;
    end
    return r;
  endfunction

  // Results are sampled at the edge that ends their one valid cycle.
  always @(posedge clk) begin
    qnorm_out_t want;
    if (rst_n && out_valid) begin
      if (unit_q_fifo.size() == 0) begin
        $error("result with no request outstanding: %p", out_data);
        errors++;
      end else begin
        want = unit_q_fifo.pop_front();
        if (out_data.out_w !== want.out_w) begin
          $error("out_w expected %0d got %0d", want.out_w, out_data.out_w);
          errors++;
        end
        if (out_data.out_x !== want.out_x) begin
          $error("out_x expected %0d got %0d", want.out_x, out_data.out_x);
          errors++;
        end
        if (out_data.out_y !== want.out_y) begin
          $error("out_y expected %0d got %0d", want.out_y, out_data.out_y);
          errors++;
        end
        if (out_data.out_z !== want.out_z) begin
          $error("out_z expected %0d got %0d", want.out_z, out_data.out_z);
          errors++;
        end
        if (out_data.passed_through !== want.passed_through) begin
          $error("passed_through expected %0b got %0b", want.passed_through,
                 out_data.passed_through);
          errors++;
        end
      end
    end
  end

  // Waits until every outstanding result has come back, then lets the
  // pipeline run empty before anything else happens.
  task automatic drain_pipeline();
    while (unit_q_fifo.size() != 0)
      @(posedge clk);
    repeat (DRAIN_CYCLES) @(posedge clk);
  endtask

  // The threshold is only changed with the pipeline empty.
  task automatic write_min_norm(input logic [15:0] value);
    drain_pipeline();
    cfg_we <= 1'b1;
    cfg_data <= value;
    @(posedge clk);
    cfg_we <= 1'b0;
    min_norm_shadow = value;
  endtask

  // Issues one request after a random gap, holds start until it is taken,
  // and files the prediction. A zero gap keeps start high back to back.
  task automatic send_request(input qnorm_in_t q, input bit has_golden,
                              input qnorm_out_t golden);
    int gap;
    qnorm_out_t pred;
    gap = $urandom_range(0, 5);
    if ($urandom_range(0, 3) == 0)
      gap = 0;
    if (gap != 0) begin
      start <= 1'b0;
      repeat (gap) @(posedge clk);
    end
    start <= 1'b1;
    in_data <= q;
    @(posedge clk);
    while (busy)
      @(posedge clk);
    pred = predict_unit_q(q, min_norm_shadow);
    if (has_golden && pred !== golden) begin
      $error("predictor disagrees with hand value: expected %p got %p", golden, pred);
      errors++;
    end
    unit_q_fifo.push_back(has_golden ? golden : pred);
  endtask

  function automatic qnorm_in_t make_q(input int w, input int x, input int y, input int z);
    qnorm_in_t q;
    q.q_w = CW'(w);
    q.q_x = CW'(x);
    q.q_y = CW'(y);
    q.q_z = CW'(z);
    return q;
  endfunction

  function automatic qnorm_out_t make_r(input int w, input int x, input int y,
                                        input int z, input bit pt);
    qnorm_out_t r;
    r.out_w = CW'(w);
    r.out_x = CW'(x);
    r.out_y = CW'(y);
    r.out_z = CW'(z);
    r.passed_through = pt;
    return r;
  endfunction

  task automatic add_row(input logic [15:0] thresh, input qnorm_in_t q,
                         input bit has_golden, input qnorm_out_t golden);
    directed_row_t row;
    row.thresh = thresh;
    row.q = q;
    row.has_golden = has_golden;
    row.golden = golden;
    directed_rows.push_back(row);
  endtask

  // Random quaternion. Most have full-range components; some are tiny so the
  // integer norm is small, and some have w near one and a small x.
  function automatic qnorm_in_t random_q();
    qnorm_in_t q;
    int kind;
    int lim;
    kind = $urandom_range(0, 9);
    q = qnorm_in_t'({$urandom, $urandom});
    if (kind < 3) begin
      lim = (kind == 0) ? 3 : ((kind == 1) ? 40 : 2000);
      q.q_w = CW'($signed($urandom_range(0, 2 * lim)) - lim);
      q.q_x = CW'($signed($urandom_range(0, 2 * lim)) - lim);
      q.q_y = CW'($signed($urandom_range(0, 2 * lim)) - lim);
      q.q_z = CW'($signed($urandom_range(0, 2 * lim)) - lim);
    end else if (kind == 3) begin
      q.q_w = CW'(ONE_Q + $signed($urandom_range(0, 200)) - 100);
      q.q_x = CW'($signed($urandom_range(0, 200)) - 100);
    end
    return q;
  endfunction

  initial begin
    logic [15:0] thresh;
    qnorm_out_t none;
    none = '0;
    rst_n = 1'b0;
    start = 1'b0;
    in_data = '0;
    cfg_we = 1'b0;
    cfg_data = '0;
    min_norm_shadow = 16'd0;
    repeat (3) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    // Zero vector passes through at the reset threshold.
    add_row(16'd0, make_q(0, 0, 0, 0), 1'b1, make_r(0, 0, 0, 0, 1'b1));
    // Unit vectors along w and x, one of each sign.
    add_row(16'd0, make_q(ONE_Q, 0, 0, 0), 1'b1, make_r(ONE_Q, 0, 0, 0, 1'b0));
    add_row(16'd0, make_q(0, -ONE_Q, 0, 0), 1'b1, make_r(0, -ONE_Q, 0, 0, 1'b0));
    // Smallest nonzero norm: a single LSB scales up to one.
    add_row(16'd0, make_q(0, 0, 1, 0), 1'b1, make_r(0, 0, ONE_Q, 0, 1'b0));
    add_row(16'd0, make_q(0, 0, 0, -1), 1'b1, make_r(0, 0, 0, -ONE_Q, 1'b0));
    // Small norm: all ones gives N = 2, so every component lands on one half.
    add_row(16'd0, make_q(1, 1, 1, 1), 1'b1, make_r(8192, 8192, 8192, 8192, 1'b0));
    add_row(16'd0, make_q(-1, 1, -1, 1), 1'b1,
            make_r(-8192, 8192, -8192, 8192, 1'b0));
    // Extremes of every component.
    add_row(16'd0, make_q(-32768, -32768, -32768, -32768), 1'b1,
            make_r(-8192, -8192, -8192, -8192, 1'b0));
    add_row(16'd0, make_q(32767, 32767, 32767, 32767), 1'b1,
            make_r(8192, 8192, 8192, 8192, 1'b0));
    add_row(16'd0, make_q(32767, -32768, 0, 1), 1'b0, none);
    add_row(16'd0, make_q(3, 4, 0, 0), 1'b0, none);
    add_row(16'd0, make_q(-12345, 2222, 31000, -7), 1'b0, none);
    // Threshold at the boundary: N = 5 passes at 5, is scaled at 4.
    add_row(16'd5, make_q(3, 4, 0, 0), 1'b1, make_r(3, 4, 0, 0, 1'b1));
    add_row(16'd4, make_q(3, -4, 0, 0), 1'b1, make_r(9830, -13107, 0, 0, 1'b0));
    // Largest threshold: the largest norm, 65536, is still above it and gets
    // scaled, while an ordinary input passes through.
    add_row(16'hFFFF, make_q(-32768, -32768, -32768, -32768), 1'b1,
            make_r(-8192, -8192, -8192, -8192, 1'b0));
    add_row(16'hFFFF, make_q(32767, -1, 100, -200), 1'b1,
            make_r(32767, -1, 100, -200, 1'b1));
    add_row(16'd16384, make_q(ONE_Q, 0, 0, 0), 1'b1, make_r(ONE_Q, 0, 0, 0, 1'b1));
    add_row(16'd16383, make_q(ONE_Q, 0, 0, 0), 1'b1, make_r(ONE_Q, 0, 0, 0, 1'b0));
    add_row(16'd0, make_q(5, 5, 5, 5), 1'b0, none);

    foreach (directed_rows[i]) begin
      if (directed_rows[i].thresh != min_norm_shadow) begin
        start <= 1'b0;
        write_min_norm(directed_rows[i].thresh);
      end
      send_request(directed_rows[i].q, directed_rows[i].has_golden,
                   directed_rows[i].golden);
    end

    // Random phases, each under a new threshold drawn from the interesting
    // range; the sender also stops to let everything drain before each one.
    for (int phase = 0; phase < 5; phase++) begin
      start <= 1'b0;
      case (phase)
        0: thresh = 16'd0;
        1: thresh = 16'hFFFF;
        2: thresh = 16'($urandom_range(0, 50));
        default: thresh = 16'($urandom_range(0, 65535) >> $urandom_range(0, 15));
      endcase
      write_min_norm(thresh);
      for (int n = 0; n < RANDOM_REQUESTS / 5; n++)
        send_request(random_q(), 1'b0, none);
    end

    start <= 1'b0;
    drain_pipeline();
    if (errors == 0)
      $display("All tests passed");
    else
      $display("Some tests failed");
    $finish;
  end

endmodule
